// ----- design/svap_pkg.sv -----
// Shared types and codes for the voice allocator: input and event words,
// command, event and pedal codes, and the controller/datapath interface.
// No dependencies.
package svap_pkg;

  localparam int MAX_VOICES_DEF = 16;
  // voice field is 4 bits, so no more than 16 voices are ever in use
  localparam int VOICE_LIMIT    = 16;
  localparam int VOICE_W        = 4;
  localparam int CNT_W          = 5;

  localparam logic [1:0] CMD_ON    = 2'd0;
  localparam logic [1:0] CMD_OFF   = 2'd1;
  localparam logic [1:0] CMD_PEDAL = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  localparam logic [1:0] EV_ON    = 2'd0;
  localparam logic [1:0] EV_OFF   = 2'd1;
  localparam logic [1:0] EV_RESET = 2'd2;

  localparam logic [1:0] PED_NONE = 2'd0;
  localparam logic [1:0] PED_HOLD = 2'd1;
  localparam logic [1:0] PED_SOST = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [7:0]  note;
    logic signed [15:0] amp;
    logic               pedal_kind;
    logic               pedal_down;
    logic [15:0]        voice_done_mask;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [VOICE_W-1:0] voice;
    logic signed [7:0]  out_note;
    logic [14:0]        out_amp;
    logic               last;
  } out_word_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_STEP,
    DP_TAIL,
    DP_FLUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_t;

  typedef struct packed {
    logic stop;
    logic is_reset;
  } stat_t;

endpackage

// ----- design/svap_ctrl.sv -----
// Sequencer for the voice allocator: load, voice scan, reset tail, flush.
// Depends on svap_pkg.
module svap_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  svap_pkg::stat_t stat,
  output svap_pkg::ctrl_t ctrl,
  output logic            busy
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_TAIL, S_FIN} state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    ctrl.op   = svap_pkg::DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.op   = svap_pkg::DP_LOAD;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.op = svap_pkg::DP_STEP;
        if (stat.stop) begin
          state_nxt = stat.is_reset ? S_TAIL : S_FIN;
        end
      end
      S_TAIL: begin
        ctrl.op   = svap_pkg::DP_TAIL;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        ctrl.op   = svap_pkg::DP_FLUSH;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> !busy)
    else $error("still busy after flush");
  a_tail_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == svap_pkg::DP_TAIL) |-> stat.is_reset)
    else $error("reset tail on a non-reset word");
`endif

endmodule

// ----- design/svap_dp.sv -----
// Voice table, scan index, pending-event and output registers.
// Depends on svap_pkg; driven by svap_ctrl.
module svap_dp #(
  parameter int MAX_VOICES = svap_pkg::MAX_VOICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  svap_pkg::in_word_t           in_word,
  input  logic                         cfg_we,
  input  logic [svap_pkg::CNT_W-1:0]   cfg_wdata,
  input  svap_pkg::ctrl_t              ctrl,
  output svap_pkg::stat_t              stat,
  output logic                         out_strobe,
  output svap_pkg::out_word_t          out_word
);

  localparam int NV = (MAX_VOICES > svap_pkg::VOICE_LIMIT) ? svap_pkg::VOICE_LIMIT
                                                            : MAX_VOICES;
  localparam int IW = (NV > 1) ? $clog2(NV) : 1;
  localparam int NW = $clog2(NV + 1);

  // voice table; stored amplitudes are never negative, so 15 bits
  logic [14:0]        v_amp_r  [NV];
  logic signed [7:0]  v_note_r [NV];
  logic [1:0]         v_ped_r  [NV];
  logic               hold_r;
  logic [NW-1:0]      n_r;

  // latched input word
  logic [1:0]         cmd_r;
  logic signed [7:0]  note_r;
  logic [14:0]        amp_r;
  logic               amp_ok_r;
  logic [1:0]         kind_r;
  logic               down_r;
  logic [NV-1:0]      done_r;
  logic [IW-1:0]      idx_r;

  svap_pkg::out_word_t pend_r, out_r;
  logic                pend_v_r, out_strobe_r;

  logic [14:0]         cur_amp, a_nxt;
  logic signed [7:0]   cur_note, nt_nxt;
  logic [1:0]          cur_ped, p_nxt, ev_kind;
  logic                cur_done, in_range, ev_v, hit;
  logic                push_v;
  svap_pkg::out_word_t push_word, flush_word;
  logic [NW-1:0]       sat;

  assign cur_amp  = v_amp_r[idx_r];
  assign cur_note = v_note_r[idx_r];
  assign cur_ped  = v_ped_r[idx_r];
  assign cur_done = done_r[idx_r];
  assign in_range = NW'(idx_r) < n_r;

  always_comb begin
    a_nxt   = cur_amp;
    nt_nxt  = cur_note;
    p_nxt   = cur_ped;
    ev_v    = 1'b0;
    ev_kind = svap_pkg::EV_OFF;
    hit     = 1'b0;
    if (in_range) begin
      case (cmd_r)
        svap_pkg::CMD_ON: begin
          if (amp_ok_r && cur_amp == '0 && cur_ped == svap_pkg::PED_NONE && cur_done) begin
            nt_nxt  = note_r;
            a_nxt   = amp_r;
            p_nxt   = hold_r ? svap_pkg::PED_HOLD : svap_pkg::PED_NONE;
            ev_v    = 1'b1;
            ev_kind = svap_pkg::EV_ON;
            hit     = 1'b1;
          end
        end
        svap_pkg::CMD_OFF: begin
          if (cur_note == note_r && cur_amp != '0) begin
            a_nxt = '0;
            ev_v  = (cur_ped == svap_pkg::PED_NONE);
          end
        end
        svap_pkg::CMD_PEDAL: begin
          if (down_r) begin
            if (cur_amp != '0 || cur_ped == svap_pkg::PED_SOST) begin
              p_nxt = kind_r;
            end
          end else if (cur_ped == kind_r) begin
            p_nxt = svap_pkg::PED_NONE;
            ev_v  = (cur_amp == '0);
          end
        end
        default: begin
          if (cur_amp != '0) begin
            a_nxt = '0;
            p_nxt = svap_pkg::PED_NONE;
            ev_v  = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    push_v    = 1'b0;
    push_word = '0;
    if (ctrl.op == svap_pkg::DP_STEP) begin
      push_v               = ev_v;
      push_word.event_kind = ev_kind;
      push_word.voice      = svap_pkg::VOICE_W'(idx_r);
      if (ev_kind == svap_pkg::EV_ON) begin
        push_word.out_note = note_r;
        push_word.out_amp  = amp_r;
      end
    end else if (ctrl.op == svap_pkg::DP_TAIL) begin
      push_v               = 1'b1;
      push_word.event_kind = svap_pkg::EV_RESET;
    end
    flush_word      = pend_r;
    flush_word.last = 1'b1;
  end

  assign sat = (cfg_wdata > svap_pkg::CNT_W'(NV)) ? NW'(NV) : cfg_wdata[NW-1:0];

  assign stat.stop     = ((NW'(idx_r) + NW'(1)) >= n_r) || hit;
  assign stat.is_reset = (cmd_r == svap_pkg::CMD_RESET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NV; v++) begin
        v_amp_r[v]  <= '0;
        v_note_r[v] <= '0;
        v_ped_r[v]  <= svap_pkg::PED_NONE;
      end
      hold_r       <= 1'b0;
      n_r          <= NW'(NV);
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      // the held word goes out when a new one pushes it or on flush
      out_strobe_r <= (push_v || ctrl.op == svap_pkg::DP_FLUSH) && pend_v_r;
      case (ctrl.op)
        svap_pkg::DP_LOAD: begin
          pend_v_r <= 1'b0;
          // only the hold flag is ever read back
          if (in_word.cmd == svap_pkg::CMD_PEDAL && !in_word.pedal_kind) begin
            hold_r <= in_word.pedal_down;
          end
        end
        svap_pkg::DP_STEP: begin
          if (in_range) begin
            v_amp_r[idx_r]  <= a_nxt;
            v_note_r[idx_r] <= nt_nxt;
            v_ped_r[idx_r]  <= p_nxt;
          end
        end
        svap_pkg::DP_FLUSH: begin
          pend_v_r <= 1'b0;
        end
        default: begin
        end
      endcase
      // a new event pushes the held one out; it is not last
      if (push_v) begin
        pend_v_r <= 1'b1;
      end
      if (cfg_we) begin
        n_r <= sat;
        for (int v = 0; v < NV; v++) begin
          if (NW'(v) >= sat) begin
            v_amp_r[v]  <= '0;
            v_note_r[v] <= '0;
            v_ped_r[v]  <= svap_pkg::PED_NONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == svap_pkg::DP_LOAD) begin
      cmd_r    <= in_word.cmd;
      note_r   <= in_word.note;
      amp_r    <= in_word.amp[14:0];
      amp_ok_r <= !in_word.amp[15] && (in_word.amp != '0);
      kind_r   <= in_word.pedal_kind ? svap_pkg::PED_SOST : svap_pkg::PED_HOLD;
      down_r   <= in_word.pedal_down;
      done_r   <= in_word.voice_done_mask[NV-1:0];
      idx_r    <= '0;
    end else if (ctrl.op == svap_pkg::DP_STEP) begin
      idx_r <= idx_r + IW'(1);
    end
    if (push_v) begin
      out_r  <= pend_r;
      pend_r <= push_word;
    end else if (ctrl.op == svap_pkg::DP_FLUSH) begin
      out_r <= flush_word;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

`ifndef SYNTH
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.last) |-> !pend_v_r)
    else $error("event held after last word");
  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (out_r.event_kind == svap_pkg::EV_ON ||
                      out_r.event_kind == svap_pkg::EV_OFF ||
                      out_r.event_kind == svap_pkg::EV_RESET))
    else $error("bad event kind");
  a_reset_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.event_kind == svap_pkg::EV_RESET) |-> out_r.last)
    else $error("generator reset not last");
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == svap_pkg::DP_LOAD) |=> !out_strobe_r)
    else $error("event word right after load");
`endif

endmodule

// ----- design/synth_voice_allocator_with_pedals_top.sv -----
// Top level of the polyphonic voice allocator with hold and sostenuto pedals.
// Depends on svap_pkg, svap_ctrl, svap_dp.
//
//  channel | ports                   | handshake
//  --------+-------------------------+------------------------------------
//  input   | start, busy, in_word    | taken when start && !busy
//  result  | out_strobe, out_word    | one-cycle strobe, cannot be held off
//  config  | cfg_we, cfg_wdata       | voice count written when cfg_we
//
// A word keeps busy high from the accepting edge through a scan of n voices
// (n being the voices in use but at least one), the tail for reset all and
// the flush, one voice per cycle. Note on stops at the voice it takes.
// Each event word is held until the next one is found or the flush cycle and
// goes out the cycle after; the flushed one carries last.
// Synchronous reset clears the table and pedal state and sets the voice
// count to its maximum. The result side has no stall.
module synth_voice_allocator_with_pedals_top #(
  parameter int MAX_VOICES = svap_pkg::MAX_VOICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  svap_pkg::in_word_t         in_word,
  output logic                       out_strobe,
  output svap_pkg::out_word_t        out_word,
  input  logic                       cfg_we,
  input  logic [svap_pkg::CNT_W-1:0] cfg_wdata
);

  svap_pkg::ctrl_t ctrl;
  svap_pkg::stat_t stat;

  svap_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  svap_dp #(
    .MAX_VOICES (MAX_VOICES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
